>>> hw/rtl/i2cbm_pkg.sv
package i2cbm_pkg;

  // Command codes carried in the mode field.
  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;
  localparam logic [2:0] CMD_NACK  = 3'd6;
  localparam logic [2:0] CMD_WAIT  = 3'd7;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned PHASE_W       = 4;

  localparam logic [PHASE_W-1:0] LEN_BYTE  = PHASE_W'(BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] LEN_START = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] LEN_ONE   = PHASE_W'(1);

  typedef logic [BITS_PER_BYTE-1:0] byte_t;
  typedef logic [PHASE_W-1:0]       phase_t;

  // One result beat.
  typedef struct packed {
    logic  scl;
    logic  sda;
    logic  busy;
    logic  done;
    byte_t rx;
    logic  nack;
  } result_t;

endpackage

>>> hw/rtl/i2c_bit_level_master.sv
// Tick-driven I2C bit-level master.
// Input channel (in_valid/in_ready): one beat is one bit-period tick. It carries
// the sampled SDA level and, while no command is active, a command in in_mode
// (start, stop, write byte, read byte, ack, nack, wait for ack); in_tx_byte is
// used only when a write starts. A mode that arrives while a command runs is
// ignored.
// Result channel (out_valid/out_ready): exactly one beat per tick, in order,
// with the SCL/SDA drive levels, busy, done, the last received byte and the
// nack flag.
// The tick is held in an input register; the command sequencer then updates its
// state and loads the result register in one pass. Throughput is one tick per
// cycle while the receiver takes results; the only loop is the state update of
// the sequencer.
// Reset leaves both registers empty, the command idle, both lines released
// (high), the received byte and nack flag zero. When the receiver stalls, the
// result register holds its beat, the input register takes one more tick, and
// in_ready then drops until the result is taken.
module i2c_bit_level_master
  import i2cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_tx_byte,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_nack_seen
);

  // Input register.
  logic       s1_valid_r;
  logic [2:0] s1_mode_r;
  byte_t      s1_tx_r;
  logic       s1_sda_r;

  // Sequencer state.
  logic [2:0] cmd_r, cmd_nxt;
  phase_t     phase_r, phase_nxt;
  byte_t      shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       nack_r, nack_nxt;
  byte_t      rx_r, rx_nxt;

  // Result register.
  logic       out_valid_r;
  result_t    res_r, res_nxt;

  logic       s1_adv;
  logic       in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Sequencer: one tick per pass.
  always_comb begin
    logic [2:0] cmd;
    phase_t     phase;
    phase_t     phase_inc;
    phase_t     len;
    byte_t      sh;
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;

    cmd       = cmd_r;
    phase     = phase_r;
    sh        = shift_r;
    scl       = scl_r;
    sda       = sda_r;
    busy      = 1'b0;
    done      = 1'b0;
    phase_inc = '0;
    len       = LEN_ONE;
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    nack_nxt  = nack_r;
    rx_nxt    = rx_r;

    // Launch a new command when idle.
    if (cmd_r == CMD_IDLE && s1_mode_r != CMD_IDLE) begin
      cmd   = s1_mode_r;
      phase = '0;
      sh    = (s1_mode_r == CMD_WRITE) ? s1_tx_r : '0;
    end

    if (cmd != CMD_IDLE) begin
      case (cmd)
        CMD_START: begin
          scl = 1'b1;
          sda = (phase == '0);
          len = LEN_START;
        end
        CMD_STOP: begin
          scl = 1'b1;
          sda = 1'b0;
        end
        CMD_WRITE: begin
          scl = 1'b1;
          sda = sh[BITS_PER_BYTE-1];
          sh  = {sh[BITS_PER_BYTE-2:0], 1'b0};
          len = LEN_BYTE;
        end
        CMD_READ: begin
          scl = 1'b0;
          sda = 1'b1;
          sh  = {sh[BITS_PER_BYTE-2:0], s1_sda_r};
          len = LEN_BYTE;
        end
        CMD_ACK: begin
          scl = 1'b1;
          sda = 1'b0;
        end
        CMD_NACK: begin
          scl = 1'b1;
          sda = 1'b1;
        end
        default: begin
          scl      = 1'b1;
          sda      = 1'b1;
          nack_nxt = s1_sda_r;
        end
      endcase
      scl_nxt   = scl;
      sda_nxt   = sda;
      phase_inc = phase + PHASE_W'(1);

      if (phase_inc >= len) begin
        done = 1'b1;
        if (cmd == CMD_STOP) begin
          sda_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b0;
        end
        if (cmd == CMD_READ) begin
          rx_nxt = sh;
        end
        cmd_nxt   = CMD_IDLE;
        phase_nxt = '0;
      end else begin
        busy      = 1'b1;
        cmd_nxt   = cmd;
        phase_nxt = phase_inc;
      end
    end

    shift_nxt    = sh;
    res_nxt.scl  = scl;
    res_nxt.sda  = sda;
    res_nxt.busy = busy;
    res_nxt.done = done;
    res_nxt.rx   = rx_nxt;
    res_nxt.nack = nack_nxt;
  end

  // Input register: control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_mode;
      s1_tx_r   <= in_tx_byte;
      s1_sda_r  <= in_sda_in;
    end
  end

  // Sequencer state advances once per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= CMD_IDLE;
      phase_r <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      nack_r  <= 1'b0;
      rx_r    <= '0;
    end else if (s1_adv) begin
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      nack_r  <= nack_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // Result register: control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = res_r.scl;
  assign out_sda_out   = res_r.sda;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_rx_byte   = res_r.rx;
  assign out_nack_seen = res_r.nack;

endmodule

>>> hw/rtl/i2cbm_checker.sv
module i2cbm_checker
  import i2cbm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_out,
  input logic       out_sda_out,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_rx_byte,
  input logic       out_nack_seen
);

  // A stalled result beat holds all of its fields.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl_out) &&
      $stable(out_sda_out) && $stable(out_busy_res) && $stable(out_done_res) &&
      $stable(out_rx_byte) && $stable(out_nack_seen))
    else $error("stalled result beat changed");

  // A tick cannot both finish a command and leave it running.
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_busy_res && out_done_res))
    else $error("busy and done together");

  // Only a read ends with SCL low, and a read always releases SDA.
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && !out_scl_out |-> out_sda_out)
    else $error("command ended with SCL low and SDA driven");

  // With the result register empty the block always takes a tick.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Two beats on the input while the output stalls fill the pipe.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
    else $error("input taken beyond pipeline depth");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_scl_out  (out_scl_out),
  .out_sda_out  (out_sda_out),
  .out_busy_res (out_busy_res),
  .out_done_res (out_done_res),
  .out_rx_byte  (out_rx_byte),
  .out_nack_seen(out_nack_seen)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import i2cbm_pkg::*;

  localparam int RAND_ITEMS = 1600;
  localparam int TAIL_ITEMS = 200;
  localparam int HOLD_AT    = 300;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN      = 8;
  localparam int LIMIT      = 400000;

  // Line predictor: tracks the command sequencer and keeps the expected result beats.
  class i2c_line_predictor;
    logic [2:0] cur_cmd;
    phase_t     phase;
    byte_t      shreg;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       nack_flg;
    byte_t      rx_hold;
    result_t    exp_beats[$];
    int         errors;

    function new();
      cur_cmd  = CMD_IDLE;
      phase    = '0;
      shreg    = '0;
      scl_lvl  = 1'b1;
      sda_lvl  = 1'b1;
      nack_flg = 1'b0;
      rx_hold  = '0;
      errors   = 0;
    endfunction

    function bit is_idle();
      return cur_cmd == CMD_IDLE;
    endfunction

    function int pending();
      return exp_beats.size();
    endfunction

    // Advance one tick and queue the beat it produces.
    function void note_tick(logic [2:0] mode, byte_t tx, logic sda_in);
      result_t r;
      phase_t  len;
      r.scl  = scl_lvl;
      r.sda  = sda_lvl;
      r.busy = 1'b0;
      r.done = 1'b0;
      // A command is only taken while the sequencer is idle.
      if (cur_cmd == CMD_IDLE && mode != CMD_IDLE) begin
        cur_cmd = mode;
        phase   = '0;
        shreg   = (mode == CMD_WRITE) ? tx : '0;
      end
      if (cur_cmd != CMD_IDLE) begin
        case (cur_cmd)
          CMD_START: begin
            r.scl = 1'b1;
            r.sda = (phase == '0);
          end
          CMD_STOP: begin
            r.scl = 1'b1;
            r.sda = 1'b0;
          end
          CMD_WRITE: begin
            r.scl = 1'b1;
            r.sda = shreg[BITS_PER_BYTE-1];
            shreg = shreg << 1;
          end
          CMD_READ: begin
            r.scl = 1'b0;
            r.sda = 1'b1;
            shreg = {shreg[BITS_PER_BYTE-2:0], sda_in};
          end
          CMD_ACK: begin
            r.scl = 1'b1;
            r.sda = 1'b0;
          end
          CMD_NACK: begin
            r.scl = 1'b1;
            r.sda = 1'b1;
          end
          default: begin
            r.scl    = 1'b1;
            r.sda    = 1'b1;
            nack_flg = sda_in;
          end
        endcase
        scl_lvl = r.scl;
        sda_lvl = r.sda;
        phase   = phase + phase_t'(1);
        if (cur_cmd == CMD_START) len = LEN_START;
        else if (cur_cmd == CMD_WRITE || cur_cmd == CMD_READ) len = LEN_BYTE;
        else len = LEN_ONE;
        // Last tick of the command: settle the lines for the next one.
        if (phase >= len) begin
          r.done = 1'b1;
          if (cur_cmd == CMD_STOP) sda_lvl = 1'b1;
          else scl_lvl = 1'b0;
          if (cur_cmd == CMD_READ) rx_hold = shreg;
          cur_cmd = CMD_IDLE;
          phase   = '0;
        end else begin
          r.busy = 1'b1;
        end
      end
      r.rx   = rx_hold;
      r.nack = nack_flg;
      exp_beats.push_back(r);
    endfunction

    // Compare one result beat against the oldest expected beat.
    function void check_beat(result_t got);
      result_t e;
      if (exp_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = exp_beats.pop_front();
      if (got.scl !== e.scl) begin
        $error("scl_out: expected %0d actual %0d", e.scl, got.scl);
        errors++;
      end
      if (got.sda !== e.sda) begin
        $error("sda_out: expected %0d actual %0d", e.sda, got.sda);
        errors++;
      end
      if (got.busy !== e.busy) begin
        $error("busy_res: expected %0d actual %0d", e.busy, got.busy);
        errors++;
      end
      if (got.done !== e.done) begin
        $error("done_res: expected %0d actual %0d", e.done, got.done);
        errors++;
      end
      if (got.rx !== e.rx) begin
        $error("rx_byte: expected %02h actual %02h", e.rx, got.rx);
        errors++;
      end
      if (got.nack !== e.nack) begin
        $error("nack_seen: expected %0d actual %0d", e.nack, got.nack);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_mode = CMD_IDLE;
  logic [7:0] in_tx_byte = '0;
  logic       in_sda_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_out;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_rx_byte;
  logic       out_nack_seen;

  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  int cycle_cnt = 0;

  i2c_line_predictor board = new();

  i2c_bit_level_master u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_tx_byte   (in_tx_byte),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_nack_seen(out_nack_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one tick, with an optional idle burst first, and note it once accepted.
  task automatic send_tick(logic [2:0] mode, byte_t tx, logic sda);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_tx_byte <= tx;
    in_sda_in  <= sda;
    do @(posedge clk); while (!in_ready);
    board.note_tick(mode, tx, sda);
  endtask

  // Issue a command and feed its remaining ticks with junk modes, which must be ignored.
  // The SDA levels come from pat, MSB first.
  task automatic run_cmd(logic [2:0] mode, byte_t tx, byte_t pat);
    int len;
    if (mode == CMD_START) len = 2;
    else if (mode == CMD_WRITE || mode == CMD_READ) len = BITS_PER_BYTE;
    else len = 1;
    for (int i = 0; i < len; i++) begin
      if (i == 0) send_tick(mode, tx, pat[7]);
      else send_tick(3'($urandom_range(0, 7)), byte_t'($urandom), pat[7-i]);
    end
  endtask

  // Every accepted result beat goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_beat({out_scl_out, out_sda_out, out_busy_res, out_done_res,
                        out_rx_byte, out_nack_seen});
    end
  end

  // Receiver side: random stalls, plus one long hold-off to back the block up.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("i2c_bit_level_master: mismatch");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [2:0] mode;
    logic [2:0] txn_q[$];
    int         pick;
    int         nbytes;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick with a stray byte, a full frame of every command,
    // both ack outcomes, and junk modes during busy ticks.
    send_tick(CMD_IDLE, 8'hFF, 1'b0);
    run_cmd(CMD_START, 8'h00, 8'hFF);
    run_cmd(CMD_WRITE, 8'hFF, 8'h00);
    run_cmd(CMD_WAIT,  8'h00, 8'h00);
    run_cmd(CMD_READ,  8'h00, 8'h5A);
    run_cmd(CMD_ACK,   8'hFF, 8'hFF);
    run_cmd(CMD_NACK,  8'h00, 8'h00);
    run_cmd(CMD_WAIT,  8'hFF, 8'hFF);
    run_cmd(CMD_STOP,  8'h00, 8'h00);
    send_tick(CMD_IDLE, 8'h00, 1'b1);

    // Random: mostly well-formed transactions with random content, some noise.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS - TAIL_ITEMS) gaps_on = 1'b0;
      if (k == HOLD_AT) hold_req = 1'b1;
      mode = 3'($urandom_range(0, 7));
      if (board.is_idle()) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          if (txn_q.size() == 0) begin
            txn_q.push_back(CMD_START);
            txn_q.push_back(CMD_WRITE);
            txn_q.push_back(CMD_WAIT);
            nbytes = $urandom_range(1, 3);
            for (int b = 0; b < nbytes; b++) begin
              if ($urandom_range(0, 1) == 0) begin
                txn_q.push_back(CMD_WRITE);
                txn_q.push_back(CMD_WAIT);
              end else begin
                txn_q.push_back(CMD_READ);
                txn_q.push_back(($urandom_range(0, 1) == 0) ? CMD_ACK : CMD_NACK);
              end
            end
            txn_q.push_back(CMD_STOP);
          end
          mode = txn_q.pop_front();
        end else if (pick == 8) begin
          mode = CMD_IDLE;
        end
      end
      send_tick(mode, byte_t'($urandom), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    // Drain, then keep checking for any stray beat.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.errors == 0) begin
      $display("i2c_bit_level_master: match");
    end else begin
      $display("i2c_bit_level_master: mismatch");
    end
    $finish;
  end

endmodule

>>> i2c_bit_level_master.f
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2c_bit_level_master.sv
hw/rtl/i2cbm_checker.sv
tb/tb_top.sv
